### rtl/ppt_pkg.sv
// Package for the point-in-polygon crossings test unit.
// Holds sizing constants, item codes and the controller/datapath command types.
// No dependencies; all other files but ppt_ram refer to it by scoped names.
`timescale 1ns / 1ps

package ppt_pkg;

  // Sizing of the vertex store and the coordinates.
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VERT_W       = 2 * COORD_BITS;

  // Arithmetic widths of the crossing test.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NUM_W  = PROD_W + 1;

  // A polygon needs at least this many vertices to enclose anything.
  localparam int POLY_MIN = 3;

  // Item codes on the mode field.
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_TEST   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             append;       // store the incoming vertex
    logic             restart;      // append starts a new polygon
    logic             start_test;   // latch the test point, clear the parity
    logic             rd_en;        // read one vertex from the store
    logic             rd_prime;     // this read only seeds the previous vertex
    logic [IDX_W-1:0] rd_addr;
    logic             load_result;  // move the parity into the output register
  } ppt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] vertex_total;
  } ppt_stat_t;

endpackage

### rtl/ppt_in_if.sv
// Input channel of the point-in-polygon test unit: valid/ready plus one item.
// Depends on ppt_pkg for the coordinate width.
`timescale 1ns / 1ps

interface ppt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic                                  start_new;
  logic signed [ppt_pkg::COORD_BITS-1:0] coord_x;
  logic signed [ppt_pkg::COORD_BITS-1:0] coord_y;

  modport source (output valid, output mode, output start_new, output coord_x,
                  output coord_y, input ready);
  modport sink (input valid, input mode, input start_new, input coord_x,
                input coord_y, output ready);
endinterface

### rtl/ppt_out_if.sv
// Output channel of the point-in-polygon test unit: valid/ready plus one result.
// Depends on ppt_pkg for the vertex count width.
`timescale 1ns / 1ps

interface ppt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         inside_res;
  logic [ppt_pkg::CNT_W-1:0]    vertices_used;
  logic                         overflowed;

  modport source (output valid, output inside_res, output vertices_used,
                  output overflowed, input ready);
  modport sink (input valid, input inside_res, input vertices_used,
                input overflowed, output ready);
endinterface

### rtl/ppt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module ppt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ppt_dp.sv
// Datapath of the point-in-polygon test unit: vertex store, vertex count,
// overflow flag, the two-stage edge crossing pipeline and the result register.
// Depends on ppt_pkg and ppt_ram.
`timescale 1ns / 1ps

module ppt_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ppt_pkg::ppt_cmd_t                     cmd_i,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] coord_x_i,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] coord_y_i,
  output ppt_pkg::ppt_stat_t                    stat_o,
  output logic                                  inside_res_o,
  output logic [ppt_pkg::CNT_W-1:0]             vertices_used_o,
  output logic                                  overflowed_o
);

  localparam int CW = ppt_pkg::COORD_BITS;
  localparam int DW = ppt_pkg::DIFF_W;
  localparam int PW = ppt_pkg::PROD_W;
  localparam int NW = ppt_pkg::NUM_W;

  logic [ppt_pkg::CNT_W-1:0]  total_q, total_d;
  logic                       overflow_q, overflow_d;
  logic                       ram_we;
  logic [ppt_pkg::IDX_W-1:0]  ram_waddr;
  logic [ppt_pkg::VERT_W-1:0] ram_rdata;

  // Vertex count and sticky overflow; start_new always leaves room.
  always_comb begin
    total_d    = total_q;
    overflow_d = overflow_q;
    ram_we     = 1'b0;
    ram_waddr  = total_q[ppt_pkg::IDX_W-1:0];
    if (cmd_i.append) begin
      if (cmd_i.restart) begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        total_d   = ppt_pkg::CNT_W'(1);
      end else if (total_q < ppt_pkg::CNT_W'(ppt_pkg::MAX_VERTICES)) begin
        ram_we  = 1'b1;
        total_d = total_q + ppt_pkg::CNT_W'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      total_q    <= total_d;
      overflow_q <= overflow_d;
    end
  end

  assign stat_o.vertex_total = total_q;

  // Vertex store, x in the upper half and y in the lower half of a word.
  ppt_ram #(
    .WIDTH (ppt_pkg::VERT_W),
    .DEPTH (ppt_pkg::MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  // Test point, latched when a test transaction is taken.
  logic signed [CW-1:0] tx_q, ty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_test) begin
      tx_q <= coord_x_i;
      ty_q <= coord_y_i;
    end
  end

  // Tags that follow each read through the RAM output register.
  logic a_valid_q, a_prime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_prime_q <= 1'b0;
    end else begin
      a_valid_q <= cmd_i.rd_en;
      a_prime_q <= cmd_i.rd_prime;
    end
  end

  // Current vertex from the store; the previous one is held in registers.
  logic signed [CW-1:0] x1, y1;
  logic signed [CW-1:0] x0_q, y0_q;

  assign x1 = $signed(ram_rdata[ppt_pkg::VERT_W-1:CW]);
  assign y1 = $signed(ram_rdata[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      x0_q <= x1;
      y0_q <= y1;
    end
  end

  // Stage one: straddle and side tests, differences and both products.
  logic                 straddle, right0, right1;
  logic signed [DW-1:0] dy, dx, rx1, ry1;
  logic signed [PW-1:0] p1, p2;

  always_comb begin
    straddle = (y0_q >= ty_q) != (y1 >= ty_q);
    right0   = x0_q >= tx_q;
    right1   = x1 >= tx_q;
    dy       = DW'(y0_q) - DW'(y1);
    dx       = DW'(x0_q) - DW'(x1);
    rx1      = DW'(x1) - DW'(tx_q);
    ry1      = DW'(y1) - DW'(ty_q);
    p1       = rx1 * dy;
    p2       = ry1 * dx;
  end

  logic                 b_valid_q;
  logic                 b_straddle_q, b_trivial_q, b_trivial_hit_q, b_d_pos_q;
  logic signed [PW-1:0] b_p1_q, b_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q && !a_prime_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_straddle_q    <= straddle;
    b_trivial_q     <= right0 == right1;
    b_trivial_hit_q <= right0;
    b_d_pos_q       <= (dy != '0) && !dy[DW-1];
    b_p1_q          <= p1;
    b_p2_q          <= p2;
  end

  // Stage two: sign-corrected compare of the crossing and parity update.
  logic signed [NW-1:0] num;
  logic                 hit;
  logic                 inside_q;

  always_comb begin
    num = NW'(b_p1_q) - NW'(b_p2_q);
    if (b_trivial_q) begin
      hit = b_trivial_hit_q;
    end else if (b_d_pos_q) begin
      hit = !num[NW-1];
    end else begin
      hit = num[NW-1] || (num == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else if (cmd_i.start_test) begin
      inside_q <= 1'b0;
    end else if (b_valid_q && b_straddle_q && hit) begin
      inside_q <= !inside_q;
    end
  end

  // Result register, loaded once the pipeline has drained.
  logic                      res_inside_q;
  logic [ppt_pkg::CNT_W-1:0] res_total_q;
  logic                      res_overflow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      res_inside_q   <= inside_q;
      res_total_q    <= total_q;
      res_overflow_q <= overflow_q;
    end
  end

  assign inside_res_o    = res_inside_q;
  assign vertices_used_o = res_total_q;
  assign overflowed_o    = res_overflow_q;

endmodule

### rtl/ppt_ctrl.sv
// Controller of the point-in-polygon test unit: takes transactions, sequences
// the edge walk through the vertex store and owns the output valid flag.
// Depends on ppt_pkg.
`timescale 1ns / 1ps

module ppt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_mode_i,
  input  logic               in_start_new_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  ppt_pkg::ppt_stat_t stat_i,
  output ppt_pkg::ppt_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [ppt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                      drain_q, drain_d;
  logic                      out_valid_q, out_valid_d;
  logic [ppt_pkg::IDX_W-1:0] last_idx;
  logic                      in_fire, out_free, poly_ok;

  assign last_idx   = ppt_pkg::IDX_W'(stat_i.vertex_total - ppt_pkg::CNT_W'(1));
  assign poly_ok    = stat_i.vertex_total >= ppt_pkg::CNT_W'(ppt_pkg::POLY_MIN);
  assign in_ready_o = state_q == ST_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state, counters and the commands for this cycle.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode_i == ppt_pkg::MODE_APPEND) begin
            cmd_o.append  = 1'b1;
            cmd_o.restart = in_start_new_i;
          end else begin
            cmd_o.start_test = 1'b1;
            state_d          = poly_ok ? ST_PRIME : ST_DONE;
          end
        end
      end
      ST_PRIME: begin
        // The walk starts with the edge from the last vertex to the first.
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_prime = 1'b1;
        cmd_o.rd_addr  = last_idx;
        idx_d          = '0;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = idx_q;
        if (idx_q == last_idx) begin
          drain_d = 1'b0;
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + ppt_pkg::IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // Waits for the last edge to pass both pipeline stages.
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // Every read stays below the vertex count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (ppt_pkg::CNT_W'(cmd_o.rd_addr) < stat_i.vertex_total))
    else $error("vertex read beyond the polygon");

  // The edge walk only runs on a real polygon.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> poly_ok)
    else $error("edge walk on a degenerate polygon");

  // A test transaction moves on to the walk or straight to the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_mode_i == ppt_pkg::MODE_TEST) |=>
      (state_q == ST_PRIME || state_q == ST_DONE))
    else $error("test transaction not started");

endmodule

### rtl/point_in_polygon_test_unit.sv
// Point-in-polygon crossings test unit. Appends are taken one per cycle while idle.
// Test on N >= 3 vertices: the result is set by the edge walk at one vertex read
// per cycle from the vertex store port and is registered once the output is free;
// next item taken the cycle after the result is registered. N <= 2: no walk.
// Reset clears control, the vertex count and the overflow flag; the vertex
// store is not cleared and only entries below the count are read.
// Depends on ppt_pkg, ppt_in_if, ppt_out_if, ppt_ctrl and ppt_dp.
`timescale 1ns / 1ps

module point_in_polygon_test_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppt_in_if.sink    in_i,
  ppt_out_if.source out_o
);

  ppt_pkg::ppt_cmd_t  cmd;
  ppt_pkg::ppt_stat_t stat;

  // Sequencer.
  ppt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_mode_i      (in_i.mode),
    .in_start_new_i (in_i.start_new),
    .in_ready_o     (in_i.ready),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // Store and crossing arithmetic.
  ppt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .coord_x_i       (in_i.coord_x),
    .coord_y_i       (in_i.coord_y),
    .stat_o          (stat),
    .inside_res_o    (out_o.inside_res),
    .vertices_used_o (out_o.vertices_used),
    .overflowed_o    (out_o.overflowed)
  );

endmodule

### tb/tb_point_in_polygon_test_unit.sv
// Testbench for the point-in-polygon crossings test unit: drives vertex appends and point
// tests, predicts every verdict with its own ray-crossing count and checks each result.
// Depends on ppt_pkg, ppt_in_if, ppt_out_if and point_in_polygon_test_unit.
`timescale 1ns / 1ps

module tb_point_in_polygon_test_unit;

  // The run limit covers the slowest correct run: a 64-vertex walk per item,
  // long stalls on both sides and one long hold-off.
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam int unsigned DRAIN_CYCLES    = ppt_pkg::MAX_VERTICES + 16;
  localparam int unsigned HOLD_CYCLES     = 400;

  typedef logic signed [ppt_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [ppt_pkg::CNT_W-1:0]             count_t;

  localparam coord_t XY_MIN = {1'b1, {(ppt_pkg::COORD_BITS-1){1'b0}}};
  localparam coord_t XY_MAX = {1'b0, {(ppt_pkg::COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic   in_poly;
    count_t used;
    logic   ovf;
  } verdict_t;

  typedef enum int {SCALE_TINY, SCALE_MID, SCALE_WIDE, SCALE_EDGE} scale_e;

  // Keeps its own copy of the polygon and queues the verdict of every accepted test.
  class polygon_checker;
    coord_t      vert_x[ppt_pkg::MAX_VERTICES];
    coord_t      vert_y[ppt_pkg::MAX_VERTICES];
    int unsigned vert_count;
    logic        overflow_flag;
    verdict_t    expected_verdicts[$];
    int unsigned errors;

    function new();
      vert_count    = 0;
      overflow_flag = 1'b0;
      errors        = 0;
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // Edge p0-p1 already straddles the test row; does it cross at or right of tx?
    // The crossing x is compared by cross-multiplication with the sign of dy folded in.
    function bit crosses_right(longint x0, longint y0, longint x1, longint y1,
                               longint tx, longint ty);
      bit     right0;
      bit     right1;
      longint dy;
      longint num;
      right0 = (x0 >= tx);
      right1 = (x1 >= tx);
      if (right0 == right1) return right0;
      dy  = y0 - y1;
      num = (x1 - tx) * dy - (y1 - ty) * (x0 - x1);
      if (dy > 0) return num >= 0;
      return num <= 0;
    endfunction

    // Walk every edge, starting with last-to-first, and toggle on each crossing.
    function logic ray_parity(coord_t tx, coord_t ty);
      int unsigned prev;
      bit          above_prev;
      bit          above_cur;
      logic        parity;
      parity = 1'b0;
      if (vert_count < ppt_pkg::POLY_MIN) return 1'b0;
      prev       = vert_count - 1;
      above_prev = (vert_y[prev] >= ty);
      for (int unsigned i = 0; i < vert_count; i++) begin
        above_cur = (vert_y[i] >= ty);
        if (above_prev != above_cur &&
            crosses_right(vert_x[prev], vert_y[prev], vert_x[i], vert_y[i], tx, ty))
          parity = ~parity;
        above_prev = above_cur;
        prev       = i;
      end
      return parity;
    endfunction

    function void note_item(logic mode, logic restart, coord_t x, coord_t y);
      verdict_t v;
      if (mode == ppt_pkg::MODE_APPEND) begin
        if (restart) vert_count = 0;
        if (vert_count < ppt_pkg::MAX_VERTICES) begin
          vert_x[vert_count] = x;
          vert_y[vert_count] = y;
          vert_count++;
        end else begin
          overflow_flag = 1'b1;
        end
      end else begin
        v.in_poly = ray_parity(x, y);
        v.used    = count_t'(vert_count);
        v.ovf     = overflow_flag;
        expected_verdicts.insert(expected_verdicts.size(), v);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no test pending (vertices_used %0d)",
                                  got.used));
      end else begin
        want = expected_verdicts.pop_front();
        if (got.in_poly !== want.in_poly)
          report_mismatch($sformatf("inside_res %0b, expected %0b (vertices_used %0d)",
                                    got.in_poly, want.in_poly, want.used));
        if (got.used !== want.used)
          report_mismatch($sformatf("vertices_used %0d, expected %0d", got.used, want.used));
        if (got.ovf !== want.ovf)
          report_mismatch($sformatf("overflowed %0b, expected %0b", got.ovf, want.ovf));
      end
    endtask
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  int unsigned    cycle_count = 0;
  int unsigned    sent_items = 0;
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    hold_request = 0;
  int unsigned    hold_left = 0;
  polygon_checker poly_pred = new();

  ppt_in_if  in_if();
  ppt_out_if out_if();

  point_in_polygon_test_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each transaction, then pick ready for the next cycle.
  initial begin
    verdict_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.in_poly = out_if.inside_res;
        got.used    = out_if.vertices_used;
        got.ovf     = out_if.overflowed;
        poly_pred.check_verdict(got);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic coord_t rand_coord(scale_e scale);
    int unsigned sel;
    case (scale)
      SCALE_TINY: return coord_t'(int'($urandom_range(12)) - 6);
      SCALE_MID:  return coord_t'(int'($urandom_range(2000)) - 1000);
      SCALE_WIDE: return coord_t'($urandom);
      default: begin
        sel = $urandom_range(5);
        case (sel)
          0:       return XY_MIN;
          1:       return XY_MAX;
          2:       return XY_MIN + coord_t'(1);
          3:       return XY_MAX - coord_t'(1);
          4:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Offer one item, with random idle cycles first, and wait for its transaction.
  task automatic send_item(input logic mode, input logic restart, input coord_t x,
                           input coord_t y);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.start_new <= restart;
    in_if.coord_x   <= x;
    in_if.coord_y   <= y;
    do @(posedge clk_i); while (!in_if.ready);
    poly_pred.note_item(mode, restart, x, y);
    sent_items++;
  endtask

  // Stop offering and wait until every queued verdict has been checked.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (poly_pred.pending() != 0);
  endtask

  // One polygon with random size and scale, then a few tests: on vertices, on edge
  // midpoints, near the shape and anywhere. Now and then a stray test or restart.
  task automatic send_random_polygon();
    coord_t      px[$];
    coord_t      py[$];
    coord_t      tx;
    coord_t      ty;
    int unsigned sides;
    int unsigned tests;
    int unsigned pick;
    int unsigned k;
    int unsigned j;
    logic        restart;
    scale_e      scale;
    pick = $urandom_range(99);
    if (pick < 6)       sides = $urandom_range(2);
    else if (pick < 80) sides = $urandom_range(8, 3);
    else if (pick < 95) sides = $urandom_range(24, 9);
    else                sides = $urandom_range(ppt_pkg::MAX_VERTICES, 25);
    scale = scale_e'($urandom_range(3));
    for (int unsigned i = 0; i < sides; i++) begin
      tx      = rand_coord(scale);
      ty      = rand_coord(scale);
      restart = (i == 0) || ($urandom_range(99) < 3);
      if (restart) begin
        px.delete();
        py.delete();
      end
      px.insert(px.size(), tx);
      py.insert(py.size(), ty);
      send_item(ppt_pkg::MODE_APPEND, restart, tx, ty);
      if ($urandom_range(99) < 3)
        send_item(ppt_pkg::MODE_TEST, 1'($urandom_range(1)), rand_coord(scale),
                  rand_coord(scale));
    end
    tests = $urandom_range(5, 1);
    for (int unsigned i = 0; i < tests; i++) begin
      pick = $urandom_range(99);
      if (px.size() != 0 && pick < 20) begin
        k  = $urandom_range(px.size() - 1);
        tx = px[k];
        ty = py[k];
      end else if (px.size() > 1 && pick < 40) begin
        k  = $urandom_range(px.size() - 1);
        j  = (k + 1) % px.size();
        tx = coord_t'((int'(px[k]) + int'(px[j])) >>> 1);
        ty = coord_t'((int'(py[k]) + int'(py[j])) >>> 1);
      end else if (pick < 85) begin
        tx = rand_coord(scale);
        ty = rand_coord(scale);
      end else begin
        tx = rand_coord(SCALE_WIDE);
        ty = rand_coord(SCALE_WIDE);
      end
      send_item(ppt_pkg::MODE_TEST, 1'($urandom_range(1)), tx, ty);
    end
  endtask

  initial begin
    int unsigned goal;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= ppt_pkg::MODE_APPEND;
    in_if.start_new <= 1'b0;
    in_if.coord_x   <= '0;
    in_if.coord_y   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty, one-vertex and two-vertex polygons all report outside.
    send_item(ppt_pkg::MODE_TEST, 1'b1, '0, '0);
    send_item(ppt_pkg::MODE_APPEND, 1'b1, XY_MIN, XY_MIN);
    send_item(ppt_pkg::MODE_TEST, 1'b0, '0, '0);
    send_item(ppt_pkg::MODE_APPEND, 1'b0, XY_MAX, XY_MIN);
    send_item(ppt_pkg::MODE_TEST, 1'b1, '0, '0);
    // Square over the whole coordinate range: center, two corners and every side.
    send_item(ppt_pkg::MODE_APPEND, 1'b0, XY_MAX, XY_MAX);
    send_item(ppt_pkg::MODE_APPEND, 1'b0, XY_MIN, XY_MAX);
    send_item(ppt_pkg::MODE_TEST, 1'b0, '0, '0);
    send_item(ppt_pkg::MODE_TEST, 1'b0, XY_MIN, XY_MIN);
    send_item(ppt_pkg::MODE_TEST, 1'b0, XY_MAX, XY_MAX);
    send_item(ppt_pkg::MODE_TEST, 1'b0, XY_MAX, '0);
    send_item(ppt_pkg::MODE_TEST, 1'b0, XY_MIN, '0);
    send_item(ppt_pkg::MODE_TEST, 1'b0, '0, XY_MIN);
    send_item(ppt_pkg::MODE_TEST, 1'b0, '0, XY_MAX);
    // Small triangle restarted over the square: on the slanted edge, in, and around.
    send_item(ppt_pkg::MODE_APPEND, 1'b1, '0, '0);
    send_item(ppt_pkg::MODE_APPEND, 1'b0, coord_t'(8), '0);
    send_item(ppt_pkg::MODE_APPEND, 1'b0, '0, coord_t'(8));
    send_item(ppt_pkg::MODE_TEST, 1'b0, coord_t'(4), coord_t'(4));
    send_item(ppt_pkg::MODE_TEST, 1'b1, coord_t'(1), coord_t'(1));
    send_item(ppt_pkg::MODE_TEST, 1'b0, coord_t'(-1), coord_t'(1));
    send_item(ppt_pkg::MODE_TEST, 1'b0, coord_t'(9), '0);
    send_item(ppt_pkg::MODE_TEST, 1'b0, coord_t'(2), coord_t'(-1));
    // A fourth vertex with a horizontal top edge.
    send_item(ppt_pkg::MODE_APPEND, 1'b0, coord_t'(-8), coord_t'(8));
    send_item(ppt_pkg::MODE_TEST, 1'b0, coord_t'(-2), coord_t'(6));
    send_item(ppt_pkg::MODE_TEST, 1'b0, coord_t'(-4), coord_t'(8));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 74;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 74;
        end
        default: begin
          idle_pct  = 25;
          stall_pct = 25;
        end
      endcase
      goal = sent_items + ITEMS_PER_PHASE;
      // Long result hold-off while items keep coming, so the input backs up.
      if (p == 0) hold_request = HOLD_CYCLES;
      // Fill the store exactly, then overrun it: the sticky flag rises here.
      if (p == 2) begin
        for (int i = 0; i < ppt_pkg::MAX_VERTICES + 2; i++) begin
          send_item(ppt_pkg::MODE_APPEND, i == 0, rand_coord(SCALE_MID),
                    rand_coord(SCALE_MID));
          if (i >= ppt_pkg::MAX_VERTICES - 1)
            send_item(ppt_pkg::MODE_TEST, 1'b0, rand_coord(SCALE_MID),
                      rand_coord(SCALE_MID));
        end
      end
      while (sent_items < goal) send_random_polygon();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (poly_pred.errors == 0 && poly_pred.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
